>>> design/ppmdd_pkg.sv
// Package for the PPM frame decoder and servo demultiplexer.
// Holds the beat structs, request and register codes and default constants.
// Depends on nothing.
package ppmdd_pkg;

    // Request codes carried in req_type and mirrored in result_kind.
    localparam logic [1:0] REQ_CAPTURE = 2'd0;
    localparam logic [1:0] REQ_TICK    = 2'd1;
    localparam logic [1:0] REQ_QUERY   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SYNC_THRESHOLD    = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_OVERFLOWS = 2'd1;
    localparam logic [1:0] CFG_ACTIVE_CHANNELS   = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [31:0] SYNC_THRESHOLD_RST    = 32'd24000;
    localparam logic [7:0]  TIMEOUT_OVERFLOWS_RST = 8'd4;
    localparam logic [3:0]  ACTIVE_CHANNELS_RST   = 4'd6;

    // Default number of stored channel widths.
    localparam int NUM_CHANNELS_DEF = 8;

    // Width of the configuration write data and of the register index.
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 2;

    // One input beat.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] capture_time;
        logic [7:0]  query_channel;
    } ppmdd_in_t;

    // One result beat.
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  pin_mask;
        logic        outputs_enabled;
        logic [15:0] reply_width;
        logic        reply_in_range;
    } ppmdd_out_t;

endpackage

>>> design/ppm_frame_decoder_demux.sv
// Top level of the PPM frame decoder and servo demultiplexer.
// Uses ppmdd_pkg for the beat structs, codes and defaults.
// Single module: state update and result register.

// The block takes one beat per clock and returns its result (if any) in the
// output register in the cycle after acceptance. s_ready is high whenever the
// output register is empty or is being emptied in the same cycle, so the
// sustained rate is one beat per clock for as long as m_ready stays high;
// the output register is the only thing that can hold the input back.
// Edge captures and overflow ticks always give a result; a width query on
// channel 0 and the unused request code give none. The width store is reset
// to zero by reset itself, so no clearing pass follows reset. Configuration
// writes take effect at the next clock edge and should only be made while
// the block is idle.
module ppm_frame_decoder_demux #(
    parameter int NUM_CHANNELS = ppmdd_pkg::NUM_CHANNELS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port
    input  logic                             cfg_wr_en,
    input  logic [ppmdd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ppmdd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  ppmdd_pkg::ppmdd_in_t             s_data,
    // Result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output ppmdd_pkg::ppmdd_out_t            m_data
);
    import ppmdd_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Configuration registers
    logic [31:0] sync_threshold_reg;
    logic [7:0]  timeout_overflows_reg;
    logic [3:0]  active_channels_reg;

    // Decoder state
    logic [15:0] overflow_count_reg, overflow_count_next;
    logic [15:0] last_capture_reg, last_capture_next;
    logic [3:0]  channel_index_reg, channel_index_next;
    logic [3:0]  pin_index_reg, pin_index_next;
    logic [7:0]  prepared_mask_reg, prepared_mask_next;
    logic        ready_flag_reg, ready_flag_next;
    logic [15:0] width_store_reg [NUM_CHANNELS];

    // Store write request
    logic             store_wr;
    logic [IDX_W-1:0] store_idx;

    // Output register
    logic       m_valid_reg, m_valid_next;
    ppmdd_out_t m_data_reg, m_data_next;

    // Working values
    logic        accept;
    logic [15:0] diff;
    logic [15:0] ovf_adj;
    logic [31:0] interval;
    logic [3:0]  pin_inc;
    logic [3:0]  ch_inc;
    logic [15:0] ovf_inc;
    logic [7:0]  q_idx;
    logic        q_in_range;

    // Handshakes: take a beat whenever the result register is free or draining.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Interval since the last capture; a wrap uses up one counted overflow.
    assign diff     = s_data.capture_time - last_capture_reg;
    assign ovf_adj  = (s_data.capture_time < last_capture_reg && overflow_count_reg != 16'd0)
                      ? overflow_count_reg - 16'd1 : overflow_count_reg;
    assign interval = {ovf_adj, diff};

    // Saturating increments.
    assign pin_inc = (pin_index_reg != 4'hF) ? pin_index_reg + 4'd1 : pin_index_reg;
    assign ch_inc  = (channel_index_reg != 4'hF) ? channel_index_reg + 4'd1
                     : channel_index_reg;
    assign ovf_inc = (overflow_count_reg != 16'hFFFF) ? overflow_count_reg + 16'd1
                     : overflow_count_reg;

    // Query index, 1-based on the wire.
    assign q_idx      = s_data.query_channel - 8'd1;
    assign q_in_range = {1'b0, q_idx} < 9'(NUM_CHANNELS);

    // Next state and result for the accepted beat.
    always_comb begin
        overflow_count_next = overflow_count_reg;
        last_capture_next   = last_capture_reg;
        channel_index_next  = channel_index_reg;
        pin_index_next      = pin_index_reg;
        prepared_mask_next  = prepared_mask_reg;
        ready_flag_next     = ready_flag_reg;
        store_wr            = 1'b0;
        store_idx           = channel_index_reg[IDX_W-1:0];
        m_valid_next        = m_valid_reg && !m_ready;
        m_data_next         = m_data_reg;

        if (accept) begin
            case (s_data.req_type)
                REQ_CAPTURE: begin
                    overflow_count_next = 16'd0;
                    last_capture_next   = s_data.capture_time;
                    pin_index_next      = pin_inc;
                    if (interval > sync_threshold_reg) begin
                        channel_index_next = 4'd0;
                    end else begin
                        store_wr           = {1'b0, channel_index_reg} < 5'(NUM_CHANNELS);
                        channel_index_next = ch_inc;
                        if (ch_inc >= active_channels_reg) begin
                            ready_flag_next = 1'b1;
                            pin_index_next  = 4'd0;
                        end
                    end
                    prepared_mask_next = pin_index_next[3] ? 8'd0
                                         : 8'd1 << pin_index_next[2:0];
                    m_valid_next                = 1'b1;
                    m_data_next.result_kind     = REQ_CAPTURE;
                    m_data_next.pin_mask        = prepared_mask_reg;
                    m_data_next.outputs_enabled = ready_flag_next;
                    m_data_next.reply_width     = 16'd0;
                    m_data_next.reply_in_range  = 1'b0;
                end
                REQ_TICK: begin
                    overflow_count_next = ovf_inc;
                    if (ovf_inc >= {8'd0, timeout_overflows_reg}) begin
                        ready_flag_next = 1'b0;
                    end
                    m_valid_next                = 1'b1;
                    m_data_next.result_kind     = REQ_TICK;
                    m_data_next.pin_mask        = 8'd0;
                    m_data_next.outputs_enabled = ready_flag_next;
                    m_data_next.reply_width     = 16'd0;
                    m_data_next.reply_in_range  = 1'b0;
                end
                REQ_QUERY: begin
                    if (s_data.query_channel != 8'd0) begin
                        m_valid_next                = 1'b1;
                        m_data_next.result_kind     = REQ_QUERY;
                        m_data_next.pin_mask        = 8'd0;
                        m_data_next.outputs_enabled = ready_flag_reg;
                        m_data_next.reply_width     = q_in_range
                                                      ? width_store_reg[q_idx[IDX_W-1:0]]
                                                      : 16'd0;
                        m_data_next.reply_in_range  = q_in_range;
                    end
                end
                default: begin
                    // The unused request code is dropped without a result.
                end
            endcase
        end
    end

    // Configuration, state and output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_threshold_reg    <= SYNC_THRESHOLD_RST;
            timeout_overflows_reg <= TIMEOUT_OVERFLOWS_RST;
            active_channels_reg   <= ACTIVE_CHANNELS_RST;
            overflow_count_reg    <= 16'd0;
            last_capture_reg      <= 16'd0;
            channel_index_reg     <= 4'd0;
            pin_index_reg         <= 4'd0;
            prepared_mask_reg     <= 8'd0;
            ready_flag_reg        <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                width_store_reg[i] <= 16'd0;
            end
            m_valid_reg           <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_SYNC_THRESHOLD:    sync_threshold_reg    <= cfg_wdata;
                    CFG_TIMEOUT_OVERFLOWS: timeout_overflows_reg <= cfg_wdata[7:0];
                    CFG_ACTIVE_CHANNELS:   active_channels_reg   <= cfg_wdata[3:0];
                    default: begin
                        // Writes beyond the register list are ignored.
                    end
                endcase
            end
            overflow_count_reg <= overflow_count_next;
            last_capture_reg   <= last_capture_next;
            channel_index_reg  <= channel_index_next;
            pin_index_reg      <= pin_index_next;
            prepared_mask_reg  <= prepared_mask_next;
            ready_flag_reg     <= ready_flag_next;
            if (store_wr) begin
                width_store_reg[store_idx] <= diff;
            end
            m_valid_reg        <= m_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

>>> design/ppmdd_checker.sv
// Port-level checker for the PPM frame decoder, bound to the top level.
// Uses ppmdd_pkg for the beat structs and request codes.
// Watches only the ports of ppm_frame_decoder_demux.
module ppmdd_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input ppmdd_pkg::ppmdd_out_t m_data
);
    import ppmdd_pkg::*;

    // A pending result holds until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed while stalled");

    // An empty output register never holds the input back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with an empty output register");

    // Only the three request kinds produce results.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.result_kind == REQ_CAPTURE || m_data.result_kind == REQ_TICK
                    || m_data.result_kind == REQ_QUERY)
        else $error("result of an unused request kind");

    // Captures drive at most one pin; ticks and queries drive none.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0(m_data.pin_mask)
                    && (m_data.result_kind == REQ_CAPTURE || m_data.pin_mask == 8'd0))
        else $error("bad pin mask");

    // A width comes back only from an in-range query.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !(m_data.result_kind == REQ_QUERY && m_data.reply_in_range)
        |-> m_data.reply_width == 16'd0)
        else $error("width reported without an in-range query");

endmodule

bind ppm_frame_decoder_demux ppmdd_checker u_ppmdd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
